@@ rtl/core/wmf_pkg.sv @@
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared widths, register indexes and reset values of the 2-D window filter.
// ----------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

	localparam int PIX_W      = 8;
	localparam int COORD_W    = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_SIZE  = 2'd0,
		REG_METHOD       = 2'd1,
		REG_PLANE_WIDTH  = 2'd2,
		REG_PLANE_HEIGHT = 2'd3
	} wmf_reg_t;

	localparam logic [2:0]            RST_KERNEL = 3'd3;
	localparam logic                  RST_METHOD = 1'b0;
	localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd1024;
	localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd1024;

	localparam logic [PIX_W-1:0] MEAN_CAP = 8'd127;

endpackage

`default_nettype wire

@@ rtl/core/wmf_stream_if.sv @@
// ----------------------------------------------------------------------------
// wmf_stream_if
// Valid/ready channels: pixel input and filtered result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmf_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface wmf_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] smoothed;
	logic [9:0] out_col;
	logic [9:0] out_row;
	logic       last_interior;

	modport source (output valid, output smoothed, output out_col, output out_row,
		output last_interior, input ready);
	modport sink   (input valid, input smoothed, input out_col, input out_row,
		input last_interior, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wmf_line_ram.sv @@
// ----------------------------------------------------------------------------
// wmf_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_line_ram #(
	parameter int DEPTH = 7168,
	parameter int AW    = 13
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

@@ rtl/core/window_mean_median_filter_2d_core.sv @@
// ----------------------------------------------------------------------------
// window_mean_median_filter_2d_core
// Raster-order box mean / median filter over a byte plane, interior only.
// ----------------------------------------------------------------------------
// A pixel that completes no interior window is only stored; the core stays idle.
// Mean: a scan of the window in the line RAM, then a serial divider, where SW is the
//   sum width (14 at MAX_KERNEL 7) and the divider numerator is SW+2 bits wide.
// Median: one pass over the window in the line RAM per result bit.
// A new pixel is taken only in the idle state, once the last result is registered.
// Reset clears counters, config and control; the line RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module window_mean_median_filter_2d_core #(
	parameter int MAX_KERNEL = 7,
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [wmf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [wmf_pkg::CFG_DATA_W-1:0] cfg_data,
	wmf_pix_if.sink                             pix,
	wmf_res_if.source                           res
);
	import wmf_pkg::*;

	localparam int KW    = $clog2(MAX_KERNEL + 1);
	localparam int SLW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int DMW   = $clog2(MAX_WIDTH + 1);
	localparam int DHW   = $clog2(MAX_HEIGHT + 1);
	localparam int XW    = ((DMW > DHW) ? DMW : DHW) + 1;
	localparam int NMAX  = MAX_KERNEL * MAX_KERNEL;
	localparam int NW    = $clog2(NMAX + 1);
	localparam int SW    = $clog2(NMAX * 255 + 1);
	localparam int NUMW  = SW + 2;
	localparam int DW    = NW + 1;
	localparam int DCW   = $clog2(NUMW + 1);
	localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_EVAL  = 6'b001000,
		ST_DIV   = 6'b010000,
		ST_DONE  = 6'b100000
	} wmf_state_t;

	wmf_state_t state_q;

	// configuration registers
	logic [2:0]            kernel_q;
	logic                  method_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;

	// raster position of the next pixel, and its line RAM slot (row mod MAX_KERNEL)
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [SLW-1:0] slot_q;

	// per-item job registers
	logic [KW-1:0]   k_q;
	logic [NW-1:0]   n_q;
	logic            mode_q;
	logic [XW-1:0]   cr_q;
	logic [XW-1:0]   cc_q;
	logic            last_q;
	logic [SLW-1:0]  row_base_q;
	logic [CW-1:0]   col_base_q;
	logic [SLW-1:0]  rs_q;
	logic [CW-1:0]   cs_q;
	logic [KW-1:0]   i_q;
	logic [KW-1:0]   j_q;
	logic            rd_valid_s1;
	logic [SW-1:0]   acc_q;
	logic [NW-1:0]   rank_q;
	logic [7:0]      prefix_q;
	logic [2:0]      bit_q;
	logic [NUMW-1:0] num_q;
	logic [DW-1:0]   rem_q;
	logic [DCW-1:0]  dcnt_q;
	logic [7:0]      result_q;

	// output register
	logic       res_valid_q;
	logic [7:0] smoothed_q;
	logic [9:0] out_col_q;
	logic [9:0] out_row_q;
	logic       out_last_q;

	// effective configuration
	logic [KW-1:0] keff;
	logic [XW-1:0] weff;
	logic [XW-1:0] heff;

	always_comb begin
		if (kernel_q == 3'd0) begin
			keff = KW'(1);
		end else if (32'(kernel_q) > MAX_KERNEL) begin
			keff = KW'(MAX_KERNEL);
		end else begin
			keff = KW'(kernel_q);
		end
		if (width_q == '0) begin
			weff = XW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			weff = XW'(MAX_WIDTH);
		end else begin
			weff = XW'(width_q);
		end
		if (height_q == '0) begin
			heff = XW'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			heff = XW'(MAX_HEIGHT);
		end else begin
			heff = XW'(height_q);
		end
	end

	// window geometry of the arriving pixel
	logic [XW-1:0] c_x, r_x, k_x, h_x, cr_x, cc_x;
	logic          has_window, interior, last_x, row_end;
	logic [SLW-1:0] base_slot;
	logic [31:0]    base_sum;

	always_comb begin
		c_x        = XW'(col_q);
		r_x        = XW'(row_q);
		k_x        = XW'(keff);
		h_x        = k_x >> 1;
		cr_x       = r_x + XW'(1) - k_x + h_x;
		cc_x       = c_x + XW'(1) - k_x + h_x;
		has_window = (r_x + XW'(1) >= k_x) && (c_x + XW'(1) >= k_x);
		interior   = has_window && (cr_x + h_x < heff) && (cc_x + h_x < weff);
		last_x     = (cr_x + h_x + XW'(1) == heff) && (cc_x + h_x + XW'(1) == weff);
		row_end    = (c_x + XW'(1) >= weff);
		base_sum   = 32'(slot_q) + MAX_KERNEL + 1 - 32'(keff);
		if (base_sum >= MAX_KERNEL) begin
			base_sum = base_sum - MAX_KERNEL;
		end
		base_slot  = SLW'(base_sum);
	end

	logic accept;
	assign pix.ready = (state_q == ST_IDLE);
	assign accept    = pix.valid && pix.ready;

	// line RAM
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;
	logic          ram_re;

	assign waddr  = AW'(32'(slot_q) * MAX_WIDTH + 32'(col_q));
	assign raddr  = AW'(32'(rs_q) * MAX_WIDTH + 32'(cs_q));
	assign ram_re = (state_q == ST_SCAN);

	wmf_line_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (pix.pixel),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// median bit-pass match: upper bits equal the prefix, current bit zero
	logic [7:0] hi_mask;
	logic       match;
	logic [3:0] shamt;
	assign shamt   = 4'(bit_q) + 4'd1;
	assign hi_mask = 8'(9'h1FF << shamt);
	assign match   = (((rdata ^ prefix_q) & hi_mask) == 8'd0) && !rdata[bit_q];

	// median decision after a pass
	logic       take_zero;
	logic [7:0] prefix_nx;
	always_comb begin
		take_zero = (SW'(rank_q) < acc_q);
		prefix_nx = prefix_q;
		if (!take_zero) begin
			prefix_nx[bit_q] = 1'b1;
		end
	end

	// divider step
	logic [DW:0]   rem_sh;
	logic [DW:0]   den_x;
	logic          q_bit;
	assign rem_sh = {rem_q, num_q[NUMW-1]};
	assign den_x  = (DW + 1)'({n_q, 1'b0});
	assign q_bit  = (rem_sh >= den_x);

	logic out_free;
	assign out_free = !res_valid_q || res.ready;

	logic [31:0] cc_wide, cr_wide;
	assign cc_wide = 32'(cc_q);
	assign cr_wide = 32'(cr_q);

	// configuration and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= RST_KERNEL;
			method_q <= RST_METHOD;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KERNEL_SIZE:  kernel_q <= cfg_data[2:0];
				REG_METHOD:       method_q <= cfg_data[0];
				REG_PLANE_WIDTH:  width_q  <= cfg_data;
				REG_PLANE_HEIGHT: height_q <= cfg_data;
				default:          kernel_q <= kernel_q;
			endcase
			// any write restarts the plane
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				if (r_x + XW'(1) >= heff) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + RW'(1);
					slot_q <= (32'(slot_q) == MAX_KERNEL - 1) ? '0 : slot_q + SLW'(1);
				end
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && interior) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (j_q == k_q - KW'(1) && i_q == k_q - KW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!mode_q) begin
						state_q <= ST_DIV;
					end else if (bit_q == 3'd0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// job datapath
	always_ff @(posedge clk) begin
		if (rd_valid_s1) begin
			acc_q <= mode_q ? acc_q + SW'(match) : acc_q + SW'(rdata);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					k_q        <= keff;
					n_q        <= NW'(32'(keff) * 32'(keff));
					rank_q     <= NW'((32'(keff) * 32'(keff)) >> 1);
					mode_q     <= method_q;
					cr_q       <= cr_x;
					cc_q       <= cc_x;
					last_q     <= last_x;
					row_base_q <= base_slot;
					col_base_q <= CW'(c_x + XW'(1) - k_x);
					rs_q       <= base_slot;
					cs_q       <= CW'(c_x + XW'(1) - k_x);
					i_q        <= '0;
					j_q        <= '0;
					acc_q      <= '0;
					prefix_q   <= 8'd0;
					bit_q      <= 3'd7;
				end
			end
			ST_SCAN: begin
				// walk the window row by row
				if (j_q == k_q - KW'(1)) begin
					j_q  <= '0;
					cs_q <= col_base_q;
					i_q  <= i_q + KW'(1);
					rs_q <= (32'(rs_q) == MAX_KERNEL - 1) ? '0 : rs_q + SLW'(1);
				end else begin
					j_q  <= j_q + KW'(1);
					cs_q <= cs_q + CW'(1);
				end
			end
			ST_EVAL: begin
				if (!mode_q) begin
					// rounded mean: (2*sum + n) / (2n)
					num_q  <= NUMW'({acc_q, 1'b0}) + NUMW'(n_q);
					rem_q  <= '0;
					dcnt_q <= DCW'(NUMW);
				end else begin
					prefix_q <= prefix_nx;
					result_q <= prefix_nx;
					if (!take_zero) begin
						rank_q <= rank_q - NW'(acc_q);
					end
					bit_q <= bit_q - 3'd1;
					rs_q  <= row_base_q;
					cs_q  <= col_base_q;
					i_q   <= '0;
					j_q   <= '0;
					acc_q <= '0;
				end
			end
			ST_DIV: begin
				if (dcnt_q == '0) begin
					result_q <= (num_q > NUMW'(MEAN_CAP)) ? MEAN_CAP : num_q[7:0];
				end else begin
					rem_q  <= q_bit ? DW'(rem_sh - den_x) : DW'(rem_sh);
					num_q  <= {num_q[NUMW-2:0], q_bit};
					dcnt_q <= dcnt_q - DCW'(1);
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

	// output register: hold a result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			smoothed_q <= result_q;
			out_col_q  <= cc_wide[9:0];
			out_row_q  <= cr_wide[9:0];
			out_last_q <= last_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.smoothed      = smoothed_q;
	assign res.out_col       = out_col_q;
	assign res.out_row       = out_row_q;
	assign res.last_interior = out_last_q;
endmodule

`default_nettype wire

@@ rtl/core/wmf_checker.sv @@
// ----------------------------------------------------------------------------
// wmf_checker
// Port-level assertions of the window filter core, bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module wmf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       pix_valid,
	input wire logic       pix_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] smoothed,
	input wire logic [9:0] out_col,
	input wire logic [9:0] out_row
);
	// no result is shown right after reset is seen asserted
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid during reset");

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(smoothed) && $stable(out_col) && $stable(out_row))
		else $error("result payload changed while stalled");

	// a result is never produced in the cycle right after a pixel transaction
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !res_valid |=> !res_valid)
		else $error("result appeared right after a pixel transaction");
endmodule

bind window_mean_median_filter_2d_core wmf_checker u_wmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.smoothed  (res.smoothed),
	.out_col   (res.out_col),
	.out_row   (res.out_row)
);

`default_nettype wire
